FILE: rtl/crmt_pkg.sv
package crmt_pkg;

  localparam int TableDepth = 16;
  localparam int MaxResults = 16;

  localparam int CoordW = 32;
  localparam int RadW   = 31;
  localparam int RootW  = 32;
  localparam int ProdW  = 2 * RootW;
  localparam int AccW   = ProdW + 1;

  localparam int InDataW  = 96;
  localparam int OutDataW = 104;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeDrain  = 2'd1,
    ModeClear  = 2'd2,
    ModeNone   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    StMerged  = 3'd0,
    StAdded   = 3'd1,
    StDropped = 3'd2,
    StSent    = 3'd3,
    StNothing = 3'd4,
    StCleared = 3'd5,
    StRsvd6   = 3'd6,
    StRsvd7   = 3'd7
  } status_e;

  typedef struct packed {
    logic load;
    logic add;
  } mac_ctl_t;

endpackage

FILE: rtl/crmt_mac.sv
module crmt_mac (
  input  logic                             clk_i,
  input  logic [crmt_pkg::RootW-1:0]       a_i,
  input  logic [crmt_pkg::RootW-1:0]       b_i,
  input  crmt_pkg::mac_ctl_t               ctl_i,
  output logic [crmt_pkg::ProdW-1:0]       prod_o,
  output logic [crmt_pkg::AccW-1:0]        acc_o
);

  logic [crmt_pkg::ProdW-1:0] prod_q;
  logic [crmt_pkg::AccW-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_i.load) begin
      acc_q <= {1'b0, prod_q};
    end else if (ctl_i.add) begin
      acc_q <= acc_q + {1'b0, prod_q};
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

FILE: rtl/crmt_isqrt.sv
module crmt_isqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [crmt_pkg::ProdW-1:0]   rad_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [crmt_pkg::RootW-1:0]   root_o
);

  localparam int RemW = crmt_pkg::RootW + 4;
  localparam int CntW = $clog2(crmt_pkg::RootW);

  logic                         busy_q, done_q;
  logic [CntW-1:0]              cnt_q;
  logic [RemW-1:0]              rem_q, rem_sh, trial;
  logic [crmt_pkg::RootW-1:0]   root_q;
  logic [crmt_pkg::ProdW-1:0]   val_q;
  logic                         ge;

  always_comb begin
    rem_sh = {rem_q[RemW-3:0], val_q[crmt_pkg::ProdW-1 -: 2]};
    trial  = RemW'({root_q, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(crmt_pkg::RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      val_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= {val_q[crmt_pkg::ProdW-3:0], 2'b00};
      if (ge) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[crmt_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[crmt_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q)
    else $error("root unit reports done while still stepping");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("root done without a run");
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cnt_q) == CntW'(crmt_pkg::RootW - 1))
    else $error("root run ended early");
`endif

endmodule

FILE: rtl/circle_region_merge_table.sv
// Circle region merge table. Words in: tuser = mode (0 insert, 1 drain, 2 clear, 3 ignored),
// tdata = x, y, radius (signed Q16.16, unsigned Q15.16). An insert examines entries one by one;
// each entry needs three products through one shared 32x32 multiplier. A merge adds the
// 32-step square root; with no match the word is appended, or dropped if the table is full.
// A drain emits up to 16 words, each unsent entry once, tlast on the final one. A clear
// empties the table. The block takes one word at a time; tready is high while the sequencer
// is idle, even if a result still waits on the output.
module circle_region_merge_table #(
  parameter int TABLE_DEPTH = crmt_pkg::TableDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // region_x [31:0], region_y [63:32], region_radius [94:64], zero [95]
  input  logic [crmt_pkg::InDataW-1:0]    s_axis_tdata_i,
  // mode [1:0]
  input  logic [1:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // entry_index [3:0], out_x [35:4], out_y [67:36], out_radius [98:68], zero [103:99]
  output logic [crmt_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // status [2:0]
  output logic [2:0]                      m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);

  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int NW    = $clog2(crmt_pkg::MaxResults + 1);
  localparam int CW    = crmt_pkg::CoordW;
  localparam int RW    = crmt_pkg::RadW;
  localparam int PadW  = crmt_pkg::OutDataW - (4 + 2 * CW + RW);

  typedef struct packed {
    logic          sent;
    logic [RW-1:0] rad;
    logic [CW-1:0] cy;
    logic [CW-1:0] cx;
  } row_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_DIFF, S_SQ0, S_SQ1, S_SQ2, S_CMP,
    S_MEAN, S_MDIFF, S_MSQ0, S_MSQ1, S_MSQ2, S_RSTART, S_ROOT,
    S_APPEND, S_DRD, S_DCHK, S_FIN
  } state_e;

  state_e                  state_q;
  logic [IdxW-1:0]         k_q;
  logic [CntW-1:0]         count_q;
  logic [NW-1:0]           n_q;
  logic [CW-1:0]           in_x_q, in_y_q;
  logic [RW-1:0]           in_r_q;
  logic [CW-1:0]           dx_q, dy_q, s_q, mx_q, my_q;
  logic                    far_q;

  row_t                    mem_q [TABLE_DEPTH];
  row_t                    row_q;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  row_t                    mem_wdata;

  logic                    pend_vld_q;
  crmt_pkg::status_e       pend_st_q;
  logic [IdxW-1:0]         pend_idx_q;
  logic [CW-1:0]           pend_x_q, pend_y_q;
  logic [RW-1:0]           pend_r_q;

  logic                    out_vld_q, out_last_q;
  crmt_pkg::status_e       out_st_q;
  logic [3:0]              out_idx_q;
  logic [CW-1:0]           out_x_q, out_y_q;
  logic [RW-1:0]           out_r_q;
  logic                    out_free;
  logic                    out_load;

  logic [CW-1:0]           mul_a, mul_b;
  crmt_pkg::mac_ctl_t      mac_ctl;
  logic [crmt_pkg::ProdW-1:0] prod;
  logic [crmt_pkg::AccW-1:0]  acc;
  logic                    root_start, root_busy, root_done;
  logic [crmt_pkg::RootW-1:0] root;

  logic [CW:0]             dfx, dfy, adx, ady, smx, smy, mdfx, mdfy, amdx, amdy;
  logic [CW-1:0]           sum_s;
  logic [CW+1:0]           msum;
  logic [RW-1:0]           nr;
  logic                    match, last_k, dchk_go, dchk_end;
  logic                    in_fire;
  crmt_pkg::mode_e         in_mode;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign in_mode  = crmt_pkg::mode_e'(s_axis_tuser_i);
  assign out_free = !out_vld_q || m_axis_tready_i;

  always_comb begin
    dfx   = {row_q.cx[CW-1], row_q.cx} - {in_x_q[CW-1], in_x_q};
    dfy   = {row_q.cy[CW-1], row_q.cy} - {in_y_q[CW-1], in_y_q};
    adx   = dfx[CW] ? -dfx : dfx;
    ady   = dfy[CW] ? -dfy : dfy;
    sum_s = {1'b0, row_q.rad} + {1'b0, in_r_q};
    smx   = {row_q.cx[CW-1], row_q.cx} + {in_x_q[CW-1], in_x_q};
    smy   = {row_q.cy[CW-1], row_q.cy} + {in_y_q[CW-1], in_y_q};
    mdfx  = {mx_q[CW-1], mx_q} - {in_x_q[CW-1], in_x_q};
    mdfy  = {my_q[CW-1], my_q} - {in_y_q[CW-1], in_y_q};
    amdx  = mdfx[CW] ? -mdfx : mdfx;
    amdy  = mdfy[CW] ? -mdfy : mdfy;
    msum  = (CW+2)'(root) + (CW+2)'(row_q.rad) + (CW+2)'(in_r_q);
    nr    = (msum[CW+1:RW+1] != '0) ? {RW{1'b1}} : msum[RW:1];
    match = !far_q && (acc < {1'b0, prod});
    last_k   = (CntW'(k_q) + CntW'(1)) == count_q;
    dchk_go  = !row_q.sent && (!pend_vld_q || out_free);
    dchk_end = last_k || (dchk_go && (n_q + NW'(1) == NW'(crmt_pkg::MaxResults)));
    out_load = ((state_q == S_DCHK) && dchk_go && pend_vld_q)
               || ((state_q == S_FIN) && out_free);
  end

  always_comb begin
    mul_a        = dx_q;
    mul_b        = dx_q;
    mac_ctl.load = 1'b0;
    mac_ctl.add  = 1'b0;
    unique case (state_q)
      S_SQ1, S_MSQ1: begin
        mul_a        = dy_q;
        mul_b        = dy_q;
        mac_ctl.load = 1'b1;
      end
      S_SQ2: begin
        mul_a       = s_q;
        mul_b       = s_q;
        mac_ctl.add = 1'b1;
      end
      S_MSQ2: begin
        mac_ctl.add = 1'b1;
      end
      default: begin
        mul_a = dx_q;
      end
    endcase
  end

  assign root_start = (state_q == S_RSTART);

  crmt_mac u_mac (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ctl_i  (mac_ctl),
    .prod_o (prod),
    .acc_o  (acc)
  );

  crmt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (acc[crmt_pkg::ProdW-1:0]),
    .busy_o  (root_busy),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = row_q;
    unique case (state_q)
      S_ROOT: begin
        mem_we    = root_done;
        mem_wdata = '{sent: row_q.sent, rad: nr, cy: my_q, cx: mx_q};
      end
      S_APPEND: begin
        mem_we    = count_q < CntW'(TABLE_DEPTH);
        mem_waddr = IdxW'(count_q);
        mem_wdata = '{sent: 1'b0, rad: in_r_q, cy: in_y_q, cx: in_x_q};
      end
      S_DCHK: begin
        mem_we         = dchk_go;
        mem_wdata.sent = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    row_q <= mem_q[k_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      k_q        <= '0;
      count_q    <= '0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_st_q   <= crmt_pkg::StNothing;
      out_idx_q  <= '0;
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_r_q    <= '0;
      pend_st_q  <= crmt_pkg::StNothing;
      pend_idx_q <= '0;
      pend_x_q   <= '0;
      pend_y_q   <= '0;
      pend_r_q   <= '0;
      in_x_q     <= '0;
      in_y_q     <= '0;
      in_r_q     <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
      s_q        <= '0;
      mx_q       <= '0;
      my_q       <= '0;
      far_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            in_x_q     <= s_axis_tdata_i[CW-1:0];
            in_y_q     <= s_axis_tdata_i[2*CW-1:CW];
            in_r_q     <= s_axis_tdata_i[2*CW+RW-1:2*CW];
            k_q        <= '0;
            n_q        <= '0;
            pend_vld_q <= (in_mode == crmt_pkg::ModeClear);
            unique case (in_mode)
              crmt_pkg::ModeInsert: begin
                state_q <= (count_q == '0) ? S_APPEND : S_RD;
              end
              crmt_pkg::ModeDrain: begin
                state_q <= (count_q == '0) ? S_FIN : S_DRD;
              end
              crmt_pkg::ModeClear: begin
                count_q    <= '0;
                pend_st_q  <= crmt_pkg::StCleared;
                pend_idx_q <= '0;
                pend_x_q   <= '0;
                pend_y_q   <= '0;
                pend_r_q   <= '0;
                state_q    <= S_FIN;
              end
              crmt_pkg::ModeNone: begin
                state_q <= S_IDLE;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          dx_q    <= adx[CW-1:0];
          dy_q    <= ady[CW-1:0];
          far_q   <= adx[CW] || ady[CW];
          s_q     <= sum_s;
          state_q <= S_SQ0;
        end
        S_SQ0: begin
          state_q <= S_SQ1;
        end
        S_SQ1: begin
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          priority if (match) begin
            state_q <= S_MEAN;
          end else if (last_k) begin
            state_q <= S_APPEND;
          end else begin
            k_q     <= k_q + IdxW'(1);
            state_q <= S_RD;
          end
        end
        S_MEAN: begin
          mx_q    <= smx[CW:1];
          my_q    <= smy[CW:1];
          state_q <= S_MDIFF;
        end
        S_MDIFF: begin
          dx_q    <= amdx[CW-1:0];
          dy_q    <= amdy[CW-1:0];
          state_q <= S_MSQ0;
        end
        S_MSQ0: begin
          state_q <= S_MSQ1;
        end
        S_MSQ1: begin
          state_q <= S_MSQ2;
        end
        S_MSQ2: begin
          state_q <= S_RSTART;
        end
        S_RSTART: begin
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (root_done) begin
            pend_vld_q <= 1'b1;
            pend_st_q  <= crmt_pkg::StMerged;
            pend_idx_q <= k_q;
            pend_x_q   <= mx_q;
            pend_y_q   <= my_q;
            pend_r_q   <= nr;
            state_q    <= S_FIN;
          end
        end
        S_APPEND: begin
          pend_vld_q <= 1'b1;
          if (count_q < CntW'(TABLE_DEPTH)) begin
            pend_st_q  <= crmt_pkg::StAdded;
            pend_idx_q <= IdxW'(count_q);
            pend_x_q   <= in_x_q;
            pend_y_q   <= in_y_q;
            pend_r_q   <= in_r_q;
            count_q    <= count_q + CntW'(1);
          end else begin
            pend_st_q  <= crmt_pkg::StDropped;
            pend_idx_q <= '0;
            pend_x_q   <= '0;
            pend_y_q   <= '0;
            pend_r_q   <= '0;
          end
          state_q <= S_FIN;
        end
        S_DRD: begin
          state_q <= S_DCHK;
        end
        S_DCHK: begin
          if (row_q.sent || dchk_go) begin
            if (dchk_go) begin
              if (pend_vld_q) begin
                out_last_q <= 1'b0;
                out_st_q   <= pend_st_q;
                out_idx_q  <= 4'(pend_idx_q);
                out_x_q    <= pend_x_q;
                out_y_q    <= pend_y_q;
                out_r_q    <= pend_r_q;
              end
              pend_vld_q <= 1'b1;
              pend_st_q  <= crmt_pkg::StSent;
              pend_idx_q <= k_q;
              pend_x_q   <= row_q.cx;
              pend_y_q   <= row_q.cy;
              pend_r_q   <= row_q.rad;
              n_q        <= n_q + NW'(1);
            end
            if (dchk_end) begin
              state_q <= S_FIN;
            end else begin
              k_q     <= k_q + IdxW'(1);
              state_q <= S_DRD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_last_q <= 1'b1;
            if (pend_vld_q) begin
              out_st_q  <= pend_st_q;
              out_idx_q <= 4'(pend_idx_q);
              out_x_q   <= pend_x_q;
              out_y_q   <= pend_y_q;
              out_r_q   <= pend_r_q;
            end else begin
              out_st_q  <= crmt_pkg::StNothing;
              out_idx_q <= '0;
              out_x_q   <= '0;
              out_y_q   <= '0;
              out_r_q   <= '0;
            end
            pend_vld_q <= 1'b0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_r_q, out_y_q, out_x_q, out_idx_q};
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_idle_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !root_busy)
    else $error("ready while root unit is busy");
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_st_q == crmt_pkg::StNothing || out_st_q == crmt_pkg::StCleared
      || out_st_q == crmt_pkg::StDropped) |-> m_axis_tdata_o == '0)
    else $error("empty result carries data");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("pending result overwritten");
  a_drain_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= NW'(crmt_pkg::MaxResults))
    else $error("drain emitted too many words");
`endif

endmodule

FILE: tb/circle_region_merge_table_tb.sv
module circle_region_merge_table_tb;

  typedef struct {
    crmt_pkg::status_e status;
    logic [3:0]        idx;
    logic [31:0]       x;
    logic [31:0]       y;
    logic [30:0]       rad;
    logic              last;
  } region_word_t;

  typedef struct {
    crmt_pkg::mode_e mode;
    logic [31:0]     x;
    logic [31:0]     y;
    logic [30:0]     r;
    bit              typed;
    region_word_t    word;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  // region_x [31:0], region_y [63:32], region_radius [94:64], zero [95]
  logic [crmt_pkg::InDataW-1:0]  s_axis_tdata;
  // mode [1:0]
  logic [1:0]                    s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b1;
  // entry_index [3:0], out_x [35:4], out_y [67:36], out_radius [98:68], zero [103:99]
  logic [crmt_pkg::OutDataW-1:0] m_axis_tdata;
  // status [2:0]
  logic [2:0]                    m_axis_tuser;
  logic                          m_axis_tlast;

  logic signed [31:0] tab_cx [crmt_pkg::TableDepth];
  logic signed [31:0] tab_cy [crmt_pkg::TableDepth];
  logic [30:0]        tab_rad [crmt_pkg::TableDepth];
  bit                 tab_sent [crmt_pkg::TableDepth];
  int                 tab_count = 0;

  region_word_t step_words [$];
  region_word_t pending_words [$];
  stim_row_t    rows [$];

  int mismatch_count = 0;
  int rx_hold = 0;
  bit steady_tx = 1'b0;
  bit steady_rx = 1'b0;

  circle_region_merge_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  always begin
    #6 clk_i = ~clk_i;
  end

  function automatic void add_step(region_word_t w);
    step_words = {step_words, w};
  endfunction

  function automatic void add_pending(region_word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void add_row(stim_row_t r);
    rows = {rows, r};
  endfunction

  function automatic region_word_t make_word(crmt_pkg::status_e st, int idx, logic [31:0] x,
                                             logic [31:0] y, logic [30:0] r, logic last);
    region_word_t w;
    w.status = st;
    w.idx    = 4'(idx);
    w.x      = x;
    w.y      = y;
    w.rad    = r;
    w.last   = last;
    return w;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  task automatic table_apply(input crmt_pkg::mode_e mode, input logic [31:0] x,
                             input logic [31:0] y, input logic [30:0] r);
    longint          nx, ny, ex, ey, mx, my;
    longint unsigned dx, dy, s, s2, dx2, dy2, d, nr;
    int              k, n;
    bit              hit;
    step_words.delete();
    nx = longint'($signed(x));
    ny = longint'($signed(y));
    case (mode)
      crmt_pkg::ModeInsert: begin
        hit = 1'b0;
        for (k = 0; k < tab_count && !hit; k++) begin
          ex = longint'(tab_cx[k]);
          ey = longint'(tab_cy[k]);
          dx = (ex >= nx) ? ex - nx : nx - ex;
          dy = (ey >= ny) ? ey - ny : ny - ey;
          if (dx < 64'h1_0000_0000 && dy < 64'h1_0000_0000) begin
            s   = 64'(tab_rad[k]) + 64'(r);
            s2  = s * s;
            dx2 = dx * dx;
            dy2 = dy * dy;
            if (dx2 < s2 && dy2 < s2 - dx2) begin
              mx = (ex + nx) >>> 1;
              my = (ey + ny) >>> 1;
              dx = (mx >= nx) ? mx - nx : nx - mx;
              dy = (my >= ny) ? my - ny : ny - my;
              d  = root_floor(dx * dx + dy * dy);
              nr = (d + 64'(tab_rad[k]) + 64'(r)) >> 1;
              if (nr > 64'h7FFF_FFFF) nr = 64'h7FFF_FFFF;
              tab_cx[k]  = mx[31:0];
              tab_cy[k]  = my[31:0];
              tab_rad[k] = nr[30:0];
              add_step(make_word(crmt_pkg::StMerged, k, mx[31:0], my[31:0], nr[30:0], 1'b1));
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          if (tab_count < crmt_pkg::TableDepth) begin
            tab_cx[tab_count]   = x;
            tab_cy[tab_count]   = y;
            tab_rad[tab_count]  = r;
            tab_sent[tab_count] = 1'b0;
            add_step(make_word(crmt_pkg::StAdded, tab_count, x, y, r, 1'b1));
            tab_count++;
          end else begin
            add_step(make_word(crmt_pkg::StDropped, 0, '0, '0, '0, 1'b1));
          end
        end
      end
      crmt_pkg::ModeDrain: begin
        n = 0;
        for (k = 0; k < tab_count && n < crmt_pkg::MaxResults; k++) begin
          if (!tab_sent[k]) begin
            tab_sent[k] = 1'b1;
            add_step(make_word(crmt_pkg::StSent, k, tab_cx[k], tab_cy[k], tab_rad[k], 1'b0));
            n++;
          end
        end
        if (n == 0) add_step(make_word(crmt_pkg::StNothing, 0, '0, '0, '0, 1'b1));
        else step_words[step_words.size() - 1].last = 1'b1;
      end
      crmt_pkg::ModeClear: begin
        tab_count = 0;
        add_step(make_word(crmt_pkg::StCleared, 0, '0, '0, '0, 1'b1));
      end
      default: begin
      end
    endcase
  endtask

  function automatic stim_row_t plain_row(crmt_pkg::mode_e mode, logic [31:0] x,
                                          logic [31:0] y, logic [30:0] r);
    stim_row_t row;
    row.mode  = mode;
    row.x     = x;
    row.y     = y;
    row.r     = r;
    row.typed = 1'b0;
    row.word  = make_word(crmt_pkg::StMerged, 0, '0, '0, '0, 1'b0);
    return row;
  endfunction

  function automatic stim_row_t known_row(crmt_pkg::mode_e mode, logic [31:0] x,
                                          logic [31:0] y, logic [30:0] r,
                                          crmt_pkg::status_e st, int idx,
                                          logic [31:0] ox, logic [31:0] oy,
                                          logic [30:0] orad);
    stim_row_t row;
    row       = plain_row(mode, x, y, r);
    row.typed = 1'b1;
    row.word  = make_word(st, idx, ox, oy, orad, 1'b1);
    return row;
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] c, int unsigned span);
    return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic check_word();
    region_word_t want;
    if (pending_words.size() == 0) begin
      flag_mismatch("word with none pending", m_axis_tdata[63:0], 64'd0);
      return;
    end
    want = pending_words.pop_front();
    if (m_axis_tuser !== want.status) begin
      flag_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
    end
    if (m_axis_tdata[3:0] !== want.idx) begin
      flag_mismatch("entry_index", 64'(m_axis_tdata[3:0]), 64'(want.idx));
    end
    if (m_axis_tdata[35:4] !== want.x) begin
      flag_mismatch("out_x", 64'(m_axis_tdata[35:4]), 64'(want.x));
    end
    if (m_axis_tdata[67:36] !== want.y) begin
      flag_mismatch("out_y", 64'(m_axis_tdata[67:36]), 64'(want.y));
    end
    if (m_axis_tdata[98:68] !== want.rad) begin
      flag_mismatch("out_radius", 64'(m_axis_tdata[98:68]), 64'(want.rad));
    end
    if (m_axis_tlast !== want.last) begin
      flag_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_word();
      rx_hold = steady_rx ? 0 : $urandom_range(0, 19);
      m_axis_tready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= (rx_hold == 0);
    end
  end

  task automatic send_word(input stim_row_t row);
    int gap;
    gap = steady_tx ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, row.r, row.y, row.x};
    s_axis_tuser  <= row.mode;
    do @(posedge clk_i); while (!s_axis_tready);
    table_apply(row.mode, row.x, row.y, row.r);
    if (row.typed) add_pending(row.word);
    else foreach (step_words[i]) add_pending(step_words[i]);
  endtask

  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  initial begin
    stim_row_t   row;
    int          count;
    int          sel;
    int          k;
    int unsigned span;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;

    add_row(known_row(crmt_pkg::ModeDrain, '0, '0, '0, crmt_pkg::StNothing, 0, '0, '0, '0));
    add_row(known_row(crmt_pkg::ModeInsert, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0,
                      crmt_pkg::StAdded, 0, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0));
    add_row(known_row(crmt_pkg::ModeInsert, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                      crmt_pkg::StAdded, 1, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
    add_row(plain_row(crmt_pkg::ModeInsert, '0, '0, 31'h7FFF_FFFF));
    add_row(plain_row(crmt_pkg::ModeNone, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    add_row(plain_row(crmt_pkg::ModeDrain, '0, '0, '0));
    add_row(known_row(crmt_pkg::ModeDrain, '0, '0, '0, crmt_pkg::StNothing, 0, '0, '0, '0));
    add_row(plain_row(crmt_pkg::ModeInsert, 32'h7FFF_0000, 32'h8001_0000, 31'h0002_0000));
    add_row(known_row(crmt_pkg::ModeDrain, '0, '0, '0, crmt_pkg::StNothing, 0, '0, '0, '0));
    add_row(known_row(crmt_pkg::ModeClear, '0, '0, '0, crmt_pkg::StCleared, 0, '0, '0, '0));
    for (k = 0; k < crmt_pkg::TableDepth; k++) begin
      add_row(known_row(crmt_pkg::ModeInsert, 32'(k) << 20, 32'hFFF0_0000, 31'h0001_0000,
                        crmt_pkg::StAdded, k, 32'(k) << 20, 32'hFFF0_0000, 31'h0001_0000));
    end
    add_row(known_row(crmt_pkg::ModeInsert, 32'h4000_0000, 32'h4000_0000, 31'h100,
                      crmt_pkg::StDropped, 0, '0, '0, '0));
    add_row(plain_row(crmt_pkg::ModeDrain, '0, '0, '0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i]);
    drain_wait();

    count = 0;
    while (count < 350) begin
      if (count % 40 == 0) begin
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
      end
      sel  = $urandom_range(0, 99);
      span = 1 << $urandom_range(8, 24);
      row  = plain_row(crmt_pkg::ModeInsert, $urandom, $urandom,
                       31'($urandom_range(0, span)));
      if (sel < 45 && tab_count > 0) begin
        k     = $urandom_range(0, tab_count - 1);
        row.x = jitter(tab_cx[k], span);
        row.y = jitter(tab_cy[k], span);
      end else if (sel < 70) begin
        row.x = jitter('0, 1 << $urandom_range(12, 30));
        row.y = jitter('0, 1 << $urandom_range(12, 30));
      end else if (sel < 80) begin
        row.r = 31'($urandom);
      end else if (sel < 90) begin
        row.mode = crmt_pkg::ModeDrain;
      end else if (sel < 93) begin
        row.mode = crmt_pkg::ModeClear;
      end else if (sel < 96) begin
        row.mode = crmt_pkg::ModeNone;
      end else begin
        drain_wait();
        continue;
      end
      send_word(row);
      if (row.mode != crmt_pkg::ModeNone) count++;
    end

    drain_wait();
    repeat (150) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("circle_region_merge_table regression: pass");
    end else begin
      $display("circle_region_merge_table regression: fail");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("circle_region_merge_table regression: fail");
    $finish;
  end

endmodule
